### sv/hcd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by hcd_step, http_chunked_body_decoder_core and the testbench.
package hcd_pkg;

	// Width of the chunk-size accumulator and data counter
	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// Bytes dropped after each chunk's data (the trailing CR LF)
	localparam logic [1:0] SKIP_LEN = 2'd2;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SIZE   = 3'd1,
		PH_DATA   = 3'd2,
		PH_SKIP   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		OC_COMPLETE  = 2'd0,
		OC_TRUNCATED = 2'd1,
		OC_NO_HEADER = 2'd2
	} outcome_t;

	// Size-line parse state
	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic                 started;
		logic                 ended;
	} line_t;

	// Decoder state carried from byte to byte
	typedef struct packed {
		phase_t               phase;
		logic [1:0]           header_match;
		line_t                line;
		logic                 cr_pending;
		logic [SIZE_BITS-1:0] data_remaining;
		logic [1:0]           skip_remaining;
	} state_t;

	// One result request
	typedef struct packed {
		logic       valid;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       is_last;
		outcome_t   outcome;
	} result_t;

	localparam line_t LINE_CLEAR = '{
		size:    '0,
		started: 1'b0,
		ended:   1'b0
	};

	localparam state_t STATE_RST = '{
		phase:          PH_HEADER,
		header_match:   2'd0,
		line:           LINE_CLEAR,
		cr_pending:     1'b0,
		data_remaining: '0,
		skip_remaining: 2'd0
	};

endpackage

### sv/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder: input register, decode step, result register.
// Depends on hcd_pkg and hcd_step.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | in_byte[7:0], in_last
//  out     | out_valid / out_ready| out_byte[7:0], byte_valid, is_last, outcome[1:0]
//
// One byte per clock sustained while the output is not stalled; a result passes through
// the input register, then the combinational decode step into the result register, which
// drives the output.
// Bytes that produce no result (size line, skipped CR LF, after the final chunk)
// leave the pipe without occupying the output.
// arst_n clears the valid flags and the decoder state to the header phase.
// A stalled output holds its result; the input keeps taking bytes until the
// input register also holds one that needs the output.
module http_chunked_body_decoder_core import hcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       is_last,
	output logic [1:0] outcome
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     state_q;
	state_t     state_next;
	result_t    res;
	logic       out_valid_s2;
	result_t    res_s2;
	logic       out_free;
	logic       adv_s1;

	// Stage 1 moves on when its result, if any, has room in the output register
	assign out_free = !out_valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && (!res.valid || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Decode step
	hcd_step u_step (
		.st      (state_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.st_next (state_next),
		.res     (res)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1 && res.valid) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = out_valid_s2;
	assign out_byte   = res_s2.out_byte;
	assign byte_valid = res_s2.byte_valid;
	assign is_last    = res_s2.is_last;
	assign outcome    = res_s2.outcome;

	// A result without end-of-message always carries a byte and a zero outcome
	a_mid_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> byte_valid && outcome == OC_COMPLETE)
		else $error("result without is_last lacks a byte or has an outcome");

	// Data phase is only entered with a nonzero count
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.data_remaining != '0)
		else $error("data phase with nothing remaining");

	// Skip phase always has bytes left to drop
	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_SKIP |-> state_q.skip_remaining != 2'd0)
		else $error("skip phase with nothing remaining");

	// A last byte that leaves stage 1 returns the decoder to the header phase
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> state_q.phase == PH_HEADER && state_q.header_match == 2'd0)
		else $error("decoder not reset after last byte");

endmodule

### sv/hcd_step.sv
// Per-byte decode step: next decoder state and the result for one input byte.
// Depends on hcd_pkg.
module hcd_step import hcd_pkg::*; (
	input  state_t     st,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output state_t     st_next,
	output result_t    res
);

	// Hex digit decode; letters map through the low nibble plus nine
	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
			(c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c <= "9") begin
			hex_val = c[3:0];
		end else begin
			hex_val = c[3:0] + 4'd9;
		end
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// One character of size-line content
	function automatic line_t line_char(input line_t l, input logic [7:0] c);
		line_t      r;
		logic       hx;
		logic [3:0] d;
		r  = l;
		hx = is_hex(c);
		d  = hex_val(c);
		if (!l.ended) begin
			if (!l.started) begin
				if (is_space(c)) begin
					r = l;
				end else if (!hx) begin
					r.ended = 1'b1;
				end else begin
					r.started = 1'b1;
					r.size    = SIZE_BITS'(d);
				end
			end else if (!hx) begin
				r.ended = 1'b1;
			end else if (l.size[SIZE_BITS-1 -: 4] != 4'd0) begin
				// saturate instead of shifting digits out
				r.size = '1;
			end else begin
				r.size = {l.size[SIZE_BITS-5:0], d};
			end
		end
		return r;
	endfunction

	logic                 line_end;
	logic [SIZE_BITS-1:0] dr_dec;
	logic [1:0]           sk_dec;
	line_t                line_a;
	logic                 emit;
	outcome_t             oc;

	// CR LF closing a size line
	assign line_end = st.cr_pending && (in_byte == CH_LF);
	assign dr_dec   = (st.data_remaining != '0) ? st.data_remaining - SIZE_BITS'(1) : '0;
	assign sk_dec   = (st.skip_remaining != 2'd0) ? st.skip_remaining - 2'd1 : 2'd0;
	// a held CR that is not part of CR LF counts as line content
	assign line_a   = st.cr_pending ? line_char(st.line, CH_CR) : st.line;

	// Next state
	always_comb begin
		st_next = st;
		unique case (st.phase)
			PH_HEADER: begin
				if (in_byte == CH_CR) begin
					st_next.header_match = (st.header_match == 2'd0 ||
						st.header_match == 2'd2) ? st.header_match + 2'd1 : 2'd1;
				end else if (in_byte == CH_LF && st.header_match == 2'd1) begin
					st_next.header_match = 2'd2;
				end else if (in_byte == CH_LF && st.header_match == 2'd3) begin
					st_next.header_match = 2'd0;
					st_next.phase        = PH_SIZE;
					st_next.line         = LINE_CLEAR;
					st_next.cr_pending   = 1'b0;
				end else begin
					st_next.header_match = 2'd0;
				end
			end
			PH_SIZE: begin
				if (line_end) begin
					st_next.cr_pending = 1'b0;
					if (st.line.size == '0) begin
						st_next.phase = PH_DONE;
					end else begin
						st_next.data_remaining = st.line.size;
						st_next.phase          = PH_DATA;
					end
				end else if (in_byte == CH_CR) begin
					st_next.line       = line_a;
					st_next.cr_pending = 1'b1;
				end else begin
					st_next.line       = line_char(line_a, in_byte);
					st_next.cr_pending = 1'b0;
				end
			end
			PH_DATA: begin
				st_next.data_remaining = dr_dec;
				if (dr_dec == '0) begin
					st_next.phase          = PH_SKIP;
					st_next.skip_remaining = SKIP_LEN;
				end
			end
			PH_SKIP: begin
				st_next.skip_remaining = sk_dec;
				if (sk_dec == 2'd0) begin
					st_next.phase      = PH_SIZE;
					st_next.line       = LINE_CLEAR;
					st_next.cr_pending = 1'b0;
				end
			end
			PH_DONE: begin
				st_next = st;
			end
			default: begin
				st_next = st;
			end
		endcase
		// the last byte of a buffer starts a fresh message
		if (in_last) begin
			st_next = STATE_RST;
		end
	end

	// Result
	always_comb begin
		emit = 1'b0;
		oc   = OC_TRUNCATED;
		unique case (st.phase)
			PH_HEADER: begin
				emit = 1'b1;
				// still in the header unless this byte closes CR LF CR LF
				if (!(in_byte == CH_LF && st.header_match == 2'd3)) begin
					oc = OC_NO_HEADER;
				end
			end
			PH_SIZE: begin
				if (line_end && st.line.size == '0) begin
					oc = OC_COMPLETE;
				end
			end
			PH_DATA: begin
				emit = 1'b1;
			end
			PH_SKIP: begin
				oc = OC_TRUNCATED;
			end
			PH_DONE: begin
				oc = OC_COMPLETE;
			end
			default: begin
				oc = OC_COMPLETE;
			end
		endcase
		res.valid      = emit || in_last;
		res.out_byte   = emit ? in_byte : 8'd0;
		res.byte_valid = emit;
		res.is_last    = in_last;
		res.outcome    = in_last ? oc : OC_COMPLETE;
	end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for http_chunked_body_decoder_core: directed rows, then random
// HTTP messages; checks use given results or a behavioral chunked-decoding predictor.
// Depends on hcd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module testbench;
	import hcd_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int ITEM_TARGET = 1000;
	localparam logic [SIZE_BITS-1:0] SIZE_SAT = {SIZE_BITS{1'b1}};

	// One decoded output request
	typedef struct packed {
		logic [7:0] b;
		logic       bv;
		logic       last;
		outcome_t   oc;
	} out_rec_t;

	// Directed row: byte, last flag, and an optional hand-written result
	typedef struct {
		logic [7:0] b;
		logic       l;
		bit         typed;
		out_rec_t   want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       is_last;
	logic [1:0] outcome;

	out_rec_t   expected_decoded[$];
	stim_row_t  directed_rows[$];
	logic [7:0] frame_bytes[$];
	int         errors = 0;
	int         items_sent = 0;
	int         stuck_cycles = 0;
	int         ready_left = 0;

	// Predictor state
	phase_t               dec_phase;
	logic [1:0]           crlf_seen;
	logic [SIZE_BITS-1:0] line_size;
	bit                   line_started, line_ended, line_cr;
	logic [SIZE_BITS-1:0] data_left;
	logic [1:0]           skip_left;

	http_chunked_body_decoder_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.byte_valid(byte_valid), .is_last(is_last), .outcome(outcome)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	task automatic clear_size_line();
		line_size = '0;
		line_started = 0;
		line_ended = 0;
		line_cr = 0;
	endtask

	task automatic restart_decoder();
		dec_phase = PH_HEADER;
		crlf_seen = 2'd0;
		data_left = '0;
		skip_left = 2'd0;
		clear_size_line();
	endtask

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// One content character of a size line (not the closing CR LF)
	task automatic size_char(input logic [7:0] c);
		int d;
		d = hex_digit(c);
		if (line_ended) return;
		if (!line_started) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
			if (d < 0) begin
				line_ended = 1;
				return;
			end
			line_started = 1;
			line_size = SIZE_BITS'(d);
			return;
		end
		if (d < 0) line_ended = 1;
		else if (line_size > (SIZE_SAT >> 4)) line_size = SIZE_SAT;
		else line_size = {line_size[SIZE_BITS-5:0], 4'(d)};
	endtask

	task automatic decode_byte(input logic [7:0] c, input logic l,
			output bit has, output out_rec_t r);
		bit emit;
		outcome_t oc;
		emit = 0;
		oc = OC_TRUNCATED;
		case (dec_phase)
			PH_HEADER: begin
				emit = 1;
				if (c == CH_CR)
					crlf_seen = (crlf_seen == 2'd0 || crlf_seen == 2'd2) ? crlf_seen + 2'd1 : 2'd1;
				else if (c == CH_LF && crlf_seen == 2'd1)
					crlf_seen = 2'd2;
				else if (c == CH_LF && crlf_seen == 2'd3) begin
					crlf_seen = 2'd0;
					dec_phase = PH_SIZE;
					clear_size_line();
				end else
					crlf_seen = 2'd0;
				if (dec_phase == PH_HEADER) oc = OC_NO_HEADER;
			end
			PH_SIZE: begin
				if (line_cr && c == CH_LF) begin
					line_cr = 0;
					if (line_size == '0) begin
						dec_phase = PH_DONE;
						oc = OC_COMPLETE;
					end else begin
						data_left = line_size;
						dec_phase = PH_DATA;
					end
				end else begin
					// a CR not followed by LF is ordinary line content
					if (line_cr) begin
						line_cr = 0;
						size_char(CH_CR);
					end
					if (c == CH_CR) line_cr = 1;
					else size_char(c);
				end
			end
			PH_DATA: begin
				emit = 1;
				if (data_left != '0) data_left--;
				if (data_left == '0) begin
					dec_phase = PH_SKIP;
					skip_left = SKIP_LEN;
				end
			end
			PH_SKIP: begin
				if (skip_left != 2'd0) skip_left--;
				if (skip_left == 2'd0) begin
					dec_phase = PH_SIZE;
					clear_size_line();
				end
			end
			default: oc = OC_COMPLETE;
		endcase
		has = emit || l;
		r.b = emit ? c : 8'h00;
		r.bv = emit;
		r.last = l;
		r.oc = l ? oc : OC_COMPLETE;
		if (l) restart_decoder();
	endtask

	// ---------------- request drivers ----------------

	// Mostly no gap, often a short one, now and then a long one
	function automatic int idle_cycles();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
			input out_rec_t given);
		int gap;
		bit took, has;
		out_rec_t r;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		// handshake signals are stable at the falling edge
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		decode_byte(b, l, has, r);
		if (typed) expected_decoded.push_back(given);
		else if (has) expected_decoded.push_back(r);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_decoded.size() != 0);
	endtask

	// Output side: random stalls, with occasional long stretches of steady ready
	always @(posedge clk) begin : ready_gen
		int n;
		if (ready_left > 0)
			ready_left--;
		else if (out_ready) begin
			n = idle_cycles();
			if (n > 0) begin
				out_ready <= 1'b0;
				ready_left = n - 1;
			end else
				ready_left = $urandom_range(0, 20);
		end else begin
			out_ready <= 1'b1;
			ready_left = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
		end
	end

	// ---------------- result check ----------------

	always @(negedge clk) begin : check_result
		out_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_decoded.size() == 0) begin
				$error("unexpected result: out_byte=%h byte_valid=%b is_last=%b outcome=%0d",
					out_byte, byte_valid, is_last, outcome);
				errors++;
			end else begin
				e = expected_decoded.pop_front();
				if (out_byte !== e.b) begin
					$error("out_byte: expected %h, got %h", e.b, out_byte);
					errors++;
				end
				if (byte_valid !== e.bv) begin
					$error("byte_valid: expected %b, got %b", e.bv, byte_valid);
					errors++;
				end
				if (is_last !== e.last) begin
					$error("is_last: expected %b, got %b", e.last, is_last);
					errors++;
				end
				if (outcome !== e.oc) begin
					$error("outcome: expected %0d, got %0d", e.oc, outcome);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request moving on either side
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
		else stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic add_row(input logic [7:0] b, input logic l, input bit typed,
			input logic [7:0] wb, input logic wbv, input logic wl, input outcome_t woc);
		stim_row_t s;
		s.b = b;
		s.l = l;
		s.typed = typed;
		s.want = '{b: wb, bv: wbv, last: wl, oc: woc};
		directed_rows.push_back(s);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'h30 + {4'h0, d};
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
	endfunction

	task automatic put_hex(input logic [31:0] v, input int zeros);
		int top;
		top = 1;
		for (int i = 7; i >= 0; i--)
			if (v[i*4 +: 4] != 4'h0 && top == 1 && i > 0) begin
				top = i + 1;
				break;
			end
		repeat (zeros) frame_bytes.push_back("0");
		for (int i = top - 1; i >= 0; i--) frame_bytes.push_back(hex_char(v[i*4 +: 4]));
	endtask

	task automatic put_header();
		repeat ($urandom_range(0, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
		frame_bytes.push_back(CH_CR);
		frame_bytes.push_back(CH_LF);
		frame_bytes.push_back(CH_CR);
		frame_bytes.push_back(CH_LF);
	endtask

	// Leading whitespace; a CR here is never followed by LF
	task automatic put_space();
		int p;
		repeat ($urandom_range(0, 2)) begin
			p = $urandom_range(0, 2);
			frame_bytes.push_back(p == 0 ? CH_SPACE : (p == 1 ? CH_TAB : CH_CR));
		end
	endtask

	// Chunk extension: starts with ';', may hold a lone CR
	task automatic put_ext();
		logic [7:0] c;
		if ($urandom_range(0, 2) != 0) return;
		frame_bytes.push_back(";");
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 9) == 0) begin
				frame_bytes.push_back(CH_CR);
				frame_bytes.push_back("q");
			end else begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
				frame_bytes.push_back(c);
			end
		end
	endtask

	task automatic put_crlf();
		frame_bytes.push_back(CH_CR);
		frame_bytes.push_back(CH_LF);
	endtask

	task automatic build_message();
		int kind, len, cut;
		frame_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			// well-formed chunked message with random content
			put_header();
			repeat ($urandom_range(0, 3)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				put_space();
				put_hex(len, $urandom_range(0, 2));
				put_ext();
				put_crlf();
				repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 6) == 0) begin
					frame_bytes.push_back(8'($urandom_range(0, 255)));
					frame_bytes.push_back(8'($urandom_range(0, 255)));
				end else
					put_crlf();
			end
			// zero chunk, sometimes a size line with no digits
			put_space();
			if ($urandom_range(0, 4) != 0) put_hex(0, $urandom_range(0, 2));
			put_ext();
			put_crlf();
			repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
			// broken message: cut short anywhere
			if ($urandom_range(0, 3) == 0) begin
				cut = $urandom_range(1, frame_bytes.size());
				while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
			end
		end else if (kind < 82) begin
			// long size line (8 to 12 hex digits, saturating past 8), cut off after 1 to 5 data bytes
			put_header();
			frame_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
			repeat ($urandom_range(7, 11))
				frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
			put_crlf();
			repeat ($urandom_range(1, 5)) frame_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// noise, heavy on CR and LF
			repeat ($urandom_range(1, 20))
				case ($urandom_range(0, 3))
					0: frame_bytes.push_back(CH_CR);
					1: frame_bytes.push_back(CH_LF);
					default: frame_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
		end
	endtask

	initial begin
		restart_decoder();

		// last byte in header, header completed by the last byte, then a full message
		add_row(8'h00, 1, 1, 8'h00, 1, 1, OC_NO_HEADER);
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 1, CH_LF, 1, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 1, 1, CH_LF, 1, 1, OC_TRUNCATED);
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 1, CH_LF, 1, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 1, CH_LF, 1, 0, OC_COMPLETE);
		add_row(CH_TAB, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("2", 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("z", 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(8'h00, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(8'hFF, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("a", 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("b", 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("0", 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_LF, 1, 1, 8'h00, 0, 1, OC_COMPLETE);
		// size line with only lone CRs, then a byte swallowed after the end
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 1, CH_LF, 1, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 1, CH_CR, 1, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 1, CH_LF, 1, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_CR, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row(CH_LF, 0, 0, 0, 0, 0, OC_COMPLETE);
		add_row("A", 1, 1, 8'h00, 0, 1, OC_COMPLETE);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].l, directed_rows[i].typed,
				directed_rows[i].want);
		// hold off the sender until the output side has caught up
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			build_message();
			foreach (frame_bytes[i])
				send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 0, '0);
			if ($urandom_range(0, 19) == 0) wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_decoded.size() != 0) begin
			$error("%0d expected results never arrived", expected_decoded.size());
			errors++;
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
